// ===== rtl/coap_message_parser_defines.svh =====
// ---------------------------------------------------------------------------
// CoAP message parser assertion macros
// Shared assertion wrappers; they expand to nothing when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef COAP_MESSAGE_PARSER_DEFINES_SVH
`define COAP_MESSAGE_PARSER_DEFINES_SVH

`ifndef SYNTH
// A property that must hold at every clock edge outside reset.
`define COAP_MP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("coap_message_parser assertion failed");
// A condition that must hold in the cycle after the trigger.
`define COAP_MP_ASSERT_NEXT(label, clk, rst_n, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("coap_message_parser assertion failed");
`else
`define COAP_MP_ASSERT(label, clk, rst_n, prop)
`define COAP_MP_ASSERT_NEXT(label, clk, rst_n, trig, cons)
`endif

`endif

// ===== rtl/coap_mp_pkg.sv =====
// ---------------------------------------------------------------------------
// CoAP message parser package
// Result record, protocol constants and result buffer sizing.
// ---------------------------------------------------------------------------
package coap_mp_pkg;

    // Protocol constants.
    localparam logic [1:0] COAP_VERSION       = 2'd1;
    localparam logic [1:0] COAP_TYPE_ACK      = 2'd2;
    localparam logic [3:0] COAP_MAX_TKL       = 4'd8;
    localparam logic [7:0] PAYLOAD_MARKER     = 8'hFF;
    localparam logic [3:0] NIBBLE_EXT1        = 4'd13;
    localparam logic [3:0] NIBBLE_RESERVED    = 4'd15;
    localparam logic [16:0] EXT1_BASE         = 17'd13;
    localparam logic [16:0] EXT2_BASE         = 17'd269;
    localparam logic [31:0] OPT_MEDIA_TYPE    = 32'd12;

    // Header reject reasons as reported in the summary.
    typedef enum logic [2:0] {
        REJ_NONE    = 3'd0,
        REJ_SHORT   = 3'd1,
        REJ_VERSION = 3'd2,
        REJ_TYPE    = 3'd3,
        REJ_TOKEN   = 3'd4
    } t_reject;

    // Result kinds.
    localparam logic KIND_OPTION  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // One result record.
    typedef struct packed {
        logic        kind;
        logic [31:0] option_number;
        logic [16:0] option_length;
        logic        valid_res;
        logic [2:0]  reject_reason;
        logic        parse_error;
        logic [7:0]  rsp_code;
        logic [15:0] msg_ident;
        logic [63:0] token_value;
        logic [3:0]  tok_len;
        logic [31:0] media_type;
        logic        last_result;
    } t_result;

    // Results produced by one accepted byte: none, one, or two.
    typedef struct packed {
        logic [1:0] count;
        t_result    res_a;
        t_result    res_b;
    } t_parse_out;

    // Result buffer sizing; depth is a power of two.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

endpackage

// ===== rtl/coap_mp_byte_if.sv =====
// ---------------------------------------------------------------------------
// CoAP message byte channel
// Valid/ready channel carrying one message byte and an end-of-message flag.
// ---------------------------------------------------------------------------
interface coap_mp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

// ===== rtl/coap_mp_result_if.sv =====
// ---------------------------------------------------------------------------
// CoAP parser result channel
// Valid/ready channel carrying one option or summary result.
// ---------------------------------------------------------------------------
interface coap_mp_result_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] option_number;
    logic [16:0] option_length;
    logic        valid_res;
    logic [2:0]  reject_reason;
    logic        parse_error;
    logic [7:0]  rsp_code;
    logic [15:0] msg_ident;
    logic [63:0] token_value;
    logic [3:0]  tok_len;
    logic [31:0] media_type;
    logic        last_result;

    modport source (
        output valid, output kind, output option_number, output option_length,
        output valid_res, output reject_reason, output parse_error,
        output rsp_code, output msg_ident, output token_value,
        output tok_len, output media_type, output last_result,
        input ready
    );
    modport sink (
        input valid, input kind, input option_number, input option_length,
        input valid_res, input reject_reason, input parse_error,
        input rsp_code, input msg_ident, input token_value,
        input tok_len, input media_type, input last_result,
        output ready
    );
endinterface

// ===== rtl/coap_mp_parser.sv =====
// ---------------------------------------------------------------------------
// CoAP message parser core
// Per-byte header, token and option decoder; emits up to two results a byte.
// ---------------------------------------------------------------------------
`include "coap_message_parser_defines.svh"

module coap_mp_parser
    import coap_mp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_last,
    output t_parse_out o_out
);

    typedef enum logic [2:0] {
        PH_HDR,
        PH_TOKEN,
        PH_OPTHEAD,
        PH_DELTAEXT,
        PH_LENEXT,
        PH_VALUE,
        PH_PAYLOAD,
        PH_SKIP
    } t_phase;

    localparam logic [3:0] HDR_BYTE_FLAGS  = 4'd0;
    localparam logic [3:0] HDR_BYTE_CODE   = 4'd1;
    localparam logic [3:0] HDR_BYTE_MID_HI = 4'd2;

    t_phase      r_phase,          n_phase;
    logic [3:0]  r_byte_index,     n_byte_index;
    t_reject     r_header_status,  n_header_status;
    logic [7:0]  r_code,           n_code;
    logic [15:0] r_msg_ident,      n_msg_ident;
    logic [63:0] r_token,          n_token;
    logic [3:0]  r_token_count,    n_token_count;
    logic [31:0] r_running_option, n_running_option;
    logic [3:0]  r_delta_nibble,   n_delta_nibble;
    logic [3:0]  r_length_nibble,  n_length_nibble;
    logic [16:0] r_ext_accum,      n_ext_accum;
    logic [16:0] r_value_remaining, n_value_remaining;
    logic [31:0] r_format_accum,   n_format_accum;
    logic [31:0] r_format_committed, n_format_committed;
    logic        r_error,          n_error;

    // Shared extension-byte arithmetic for the delta and length extensions.
    logic [3:0]  ext_nibble;
    logic [15:0] ext16;
    logic [16:0] ext_sum;
    logic [3:0]  ext_need;
    logic [3:0]  idx_inc;

    assign ext_nibble = (r_phase == PH_DELTAEXT) ? r_delta_nibble : r_length_nibble;
    assign ext16      = {r_ext_accum[7:0], i_data_byte};
    assign ext_sum    = {1'b0, ext16} + ((ext_nibble == NIBBLE_EXT1) ? EXT1_BASE : EXT2_BASE);
    assign ext_need   = (ext_nibble == NIBBLE_EXT1) ? 4'd1 : 4'd2;
    assign idx_inc    = r_byte_index + 4'd1;

    logic        do_begin;
    logic        do_start;
    logic        do_complete;
    logic [16:0] start_len;
    t_reject     sum_status;
    logic        sum_error;
    logic        sum_valid;
    t_result     opt_res;
    t_result     sum_res;

    always_comb begin
        n_phase            = r_phase;
        n_byte_index       = r_byte_index;
        n_header_status    = r_header_status;
        n_code             = r_code;
        n_msg_ident        = r_msg_ident;
        n_token            = r_token;
        n_token_count      = r_token_count;
        n_running_option   = r_running_option;
        n_delta_nibble     = r_delta_nibble;
        n_length_nibble    = r_length_nibble;
        n_ext_accum        = r_ext_accum;
        n_value_remaining  = r_value_remaining;
        n_format_accum     = r_format_accum;
        n_format_committed = r_format_committed;
        n_error            = r_error;
        do_begin           = 1'b0;
        do_start           = 1'b0;
        do_complete        = 1'b0;
        start_len          = '0;

        unique case (r_phase)
            PH_HDR: begin
                unique case (r_byte_index)
                    HDR_BYTE_FLAGS: begin
                        if (i_data_byte[7:6] != COAP_VERSION) begin
                            n_header_status = REJ_VERSION;
                        end else if (i_data_byte[5:4] != COAP_TYPE_ACK) begin
                            n_header_status = REJ_TYPE;
                        end else if (i_data_byte[3:0] > COAP_MAX_TKL) begin
                            n_header_status = REJ_TOKEN;
                        end else begin
                            n_header_status = REJ_NONE;
                        end
                        n_token_count = i_data_byte[3:0];
                        n_byte_index  = idx_inc;
                    end
                    HDR_BYTE_CODE: begin
                        n_code       = i_data_byte;
                        n_byte_index = idx_inc;
                    end
                    HDR_BYTE_MID_HI: begin
                        n_msg_ident  = {i_data_byte, 8'h00};
                        n_byte_index = idx_inc;
                    end
                    default: begin
                        // Low message ID byte closes the fixed header.
                        n_msg_ident  = {r_msg_ident[15:8], i_data_byte};
                        n_byte_index = '0;
                        if (r_header_status != REJ_NONE) begin
                            n_phase = PH_SKIP;
                        end else if (r_token_count != 4'd0) begin
                            n_phase = PH_TOKEN;
                        end else begin
                            n_phase = PH_OPTHEAD;
                        end
                    end
                endcase
            end
            PH_TOKEN: begin
                n_token      = {r_token[55:0], i_data_byte};
                n_byte_index = idx_inc;
                if (idx_inc >= r_token_count) begin
                    n_byte_index = '0;
                    n_phase      = PH_OPTHEAD;
                end
            end
            PH_OPTHEAD: begin
                if (i_data_byte == PAYLOAD_MARKER) begin
                    n_phase = PH_PAYLOAD;
                end else begin
                    n_delta_nibble  = i_data_byte[7:4];
                    n_length_nibble = i_data_byte[3:0];
                    if (i_data_byte[7:4] == NIBBLE_RESERVED) begin
                        n_error = 1'b1;
                        n_phase = PH_SKIP;
                    end else if (i_data_byte[7:4] >= NIBBLE_EXT1) begin
                        n_phase      = PH_DELTAEXT;
                        n_byte_index = '0;
                        n_ext_accum  = '0;
                    end else begin
                        n_running_option = r_running_option + {28'd0, i_data_byte[7:4]};
                        do_begin         = 1'b1;
                    end
                end
            end
            PH_DELTAEXT: begin
                n_ext_accum  = {1'b0, ext16};
                n_byte_index = idx_inc;
                if (idx_inc >= ext_need) begin
                    n_running_option = r_running_option + {15'd0, ext_sum};
                    do_begin         = 1'b1;
                end
            end
            PH_LENEXT: begin
                n_ext_accum  = {1'b0, ext16};
                n_byte_index = idx_inc;
                if (idx_inc >= ext_need) begin
                    do_start  = 1'b1;
                    start_len = ext_sum;
                end
            end
            PH_VALUE: begin
                n_format_accum    = {r_format_accum[23:0], i_data_byte};
                n_value_remaining = r_value_remaining - 17'd1;
                if (n_value_remaining == '0) begin
                    do_complete = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // Option delta is settled; decide how its length is given.
        if (do_begin) begin
            if (n_length_nibble >= NIBBLE_EXT1) begin
                n_phase      = PH_LENEXT;
                n_byte_index = '0;
                n_ext_accum  = '0;
            end else begin
                do_start  = 1'b1;
                start_len = {13'd0, n_length_nibble};
            end
        end

        // Option length is settled; an empty value completes at once.
        if (do_start) begin
            n_ext_accum       = start_len;
            n_value_remaining = start_len;
            n_format_accum    = '0;
            if (start_len == '0) begin
                do_complete = 1'b1;
            end else begin
                n_phase = PH_VALUE;
            end
        end

        if (do_complete) begin
            if (n_running_option == OPT_MEDIA_TYPE) begin
                n_format_committed = n_format_accum;
            end
            n_phase = PH_OPTHEAD;
        end

        opt_res.kind           = KIND_OPTION;
        opt_res.option_number  = n_running_option;
        opt_res.option_length  = n_ext_accum;
        opt_res.valid_res      = 1'b1;
        opt_res.reject_reason  = REJ_NONE;
        opt_res.parse_error    = 1'b0;
        opt_res.rsp_code       = n_code;
        opt_res.msg_ident      = n_msg_ident;
        opt_res.token_value    = n_token;
        opt_res.tok_len        = n_token_count;
        opt_res.media_type     = n_format_committed;
        opt_res.last_result    = !i_last;

        // End of message inside the header, token or an option.
        sum_status = n_header_status;
        sum_error  = n_error;
        if (n_phase == PH_HDR) begin
            sum_status = REJ_SHORT;
        end else if (n_phase == PH_TOKEN) begin
            sum_status = REJ_TOKEN;
        end else if (n_phase == PH_DELTAEXT || n_phase == PH_LENEXT ||
                     n_phase == PH_VALUE) begin
            sum_error = 1'b1;
        end
        sum_valid = (sum_status == REJ_NONE);

        sum_res.kind           = KIND_SUMMARY;
        sum_res.option_number  = '0;
        sum_res.option_length  = '0;
        sum_res.valid_res      = sum_valid;
        sum_res.reject_reason  = sum_status;
        sum_res.parse_error    = sum_valid & sum_error;
        sum_res.rsp_code       = n_code;
        sum_res.msg_ident      = n_msg_ident;
        sum_res.token_value    = sum_valid ? n_token : '0;
        sum_res.tok_len        = sum_valid ? n_token_count : '0;
        sum_res.media_type     = sum_valid ? n_format_committed : '0;
        sum_res.last_result    = 1'b1;

        o_out.res_b = sum_res;
        if (!i_accept) begin
            o_out.count = 2'd0;
            o_out.res_a = opt_res;
        end else if (do_complete && i_last) begin
            o_out.count = 2'd2;
            o_out.res_a = opt_res;
        end else if (do_complete) begin
            o_out.count = 2'd1;
            o_out.res_a = opt_res;
        end else if (i_last) begin
            o_out.count = 2'd1;
            o_out.res_a = sum_res;
        end else begin
            o_out.count = 2'd0;
            o_out.res_a = opt_res;
        end

        // The final byte returns the whole parser to its reset state.
        if (i_last) begin
            n_phase            = PH_HDR;
            n_byte_index       = '0;
            n_header_status    = REJ_NONE;
            n_code             = '0;
            n_msg_ident        = '0;
            n_token            = '0;
            n_token_count      = '0;
            n_running_option   = '0;
            n_delta_nibble     = '0;
            n_length_nibble    = '0;
            n_ext_accum        = '0;
            n_value_remaining  = '0;
            n_format_accum     = '0;
            n_format_committed = '0;
            n_error            = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase            <= PH_HDR;
            r_byte_index       <= '0;
            r_header_status    <= REJ_NONE;
            r_code             <= '0;
            r_msg_ident        <= '0;
            r_token            <= '0;
            r_token_count      <= '0;
            r_running_option   <= '0;
            r_delta_nibble     <= '0;
            r_length_nibble    <= '0;
            r_ext_accum        <= '0;
            r_value_remaining  <= '0;
            r_format_accum     <= '0;
            r_format_committed <= '0;
            r_error            <= 1'b0;
        end else if (i_accept) begin
            r_phase            <= n_phase;
            r_byte_index       <= n_byte_index;
            r_header_status    <= n_header_status;
            r_code             <= n_code;
            r_msg_ident        <= n_msg_ident;
            r_token            <= n_token;
            r_token_count      <= n_token_count;
            r_running_option   <= n_running_option;
            r_delta_nibble     <= n_delta_nibble;
            r_length_nibble    <= n_length_nibble;
            r_ext_accum        <= n_ext_accum;
            r_value_remaining  <= n_value_remaining;
            r_format_accum     <= n_format_accum;
            r_format_committed <= n_format_committed;
            r_error            <= n_error;
        end
    end

    // Conditions watched by the assertions below.
    logic chk_reset_state;
    logic chk_pair_order;
    logic chk_token_bound;
    logic chk_value_nonzero;

    assign chk_reset_state   = (r_phase == PH_HDR) && (r_byte_index == 4'd0) && !r_error;
    assign chk_pair_order    = (o_out.count != 2'd2) ||
                               (o_out.res_a.kind == KIND_OPTION &&
                                o_out.res_b.kind == KIND_SUMMARY &&
                                !o_out.res_a.last_result);
    assign chk_token_bound   = (r_phase != PH_TOKEN) ||
                               (r_token_count <= COAP_MAX_TKL &&
                                r_byte_index < r_token_count);
    assign chk_value_nonzero = (r_phase != PH_VALUE) || (r_value_remaining != 17'd0);

    `COAP_MP_ASSERT_NEXT(a_last_resets, i_clk, i_rst_n, i_accept && i_last, chk_reset_state)
    `COAP_MP_ASSERT(a_pair_order, i_clk, i_rst_n, chk_pair_order)
    `COAP_MP_ASSERT(a_token_bound, i_clk, i_rst_n, chk_token_bound)
    `COAP_MP_ASSERT(a_value_nonzero, i_clk, i_rst_n, chk_value_nonzero)

endmodule

// ===== rtl/coap_mp_result_fifo.sv =====
// ---------------------------------------------------------------------------
// CoAP parser result buffer
// Small queue that takes up to two results a cycle and releases one.
// ---------------------------------------------------------------------------
module coap_mp_result_fifo
    import coap_mp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_parse_out i_push,
    input  logic       i_pop,
    output logic       o_space,
    output logic       o_valid,
    output t_result    o_head
);

    t_result                 r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [FIFO_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [FIFO_CNT_W-1:0]   r_count,  n_count;
    logic                    pop_ok;

    assign pop_ok   = i_pop && (r_count != '0);
    assign n_wr_ptr = r_wr_ptr + FIFO_PTR_W'(i_push.count);
    assign n_rd_ptr = r_rd_ptr + FIFO_PTR_W'(pop_ok);
    assign n_count  = r_count + FIFO_CNT_W'(i_push.count) - FIFO_CNT_W'(pop_ok);

    // Room for the two results that one byte can produce.
    assign o_space = (r_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.res_a;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr_ptr + FIFO_PTR_W'(1)] <= i_push.res_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== rtl/coap_message_parser.sv =====
// ---------------------------------------------------------------------------
// CoAP message parser
// Checks a CoAP ACK header, captures code, message ID and token, and decodes
// options up to the payload marker, reporting each option and a summary.
// ---------------------------------------------------------------------------
//
//   Channel   Direction   Handshake     Payload
//   i_msg     in          valid/ready   data_byte[7:0], last
//   o_res     out         valid/ready   one option or summary result
//
// Each byte is decoded in the cycle of its transfer and its results are
// written into a four-entry result queue at that clock edge, so the first
// result can be taken in the cycle after the byte.
// A byte is taken whenever the queue has room for two results, so bytes flow
// at one per cycle while results are drained at one per cycle.
// A byte flagged last that completes an option yields two results, which
// leave the queue one at a time; an output stall backs up into i_msg.ready.
// Reset is synchronous and active low; it clears the parser and the queue.
// ---------------------------------------------------------------------------
module coap_message_parser
    import coap_mp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    coap_mp_byte_if.sink  i_msg,
    coap_mp_result_if.source o_res
);

    logic       byte_accept;
    logic       queue_space;
    logic       queue_valid;
    t_parse_out parse_out;
    t_result    head;

    // A byte transfer happens whenever the queue can hold its results.
    assign i_msg.ready = queue_space;
    assign byte_accept = i_msg.valid && queue_space;

    // Header, token and option decoding, one byte per transfer.
    coap_mp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (byte_accept),
        .i_data_byte (i_msg.data_byte),
        .i_last      (i_msg.last),
        .o_out       (parse_out)
    );

    // Result queue separating the byte side from the result side.
    coap_mp_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (parse_out),
        .i_pop   (o_res.ready),
        .o_space (queue_space),
        .o_valid (queue_valid),
        .o_head  (head)
    );

    assign o_res.valid          = queue_valid;
    assign o_res.kind           = head.kind;
    assign o_res.option_number  = head.option_number;
    assign o_res.option_length  = head.option_length;
    assign o_res.valid_res      = head.valid_res;
    assign o_res.reject_reason  = head.reject_reason;
    assign o_res.parse_error    = head.parse_error;
    assign o_res.rsp_code       = head.rsp_code;
    assign o_res.msg_ident      = head.msg_ident;
    assign o_res.token_value    = head.token_value;
    assign o_res.tok_len        = head.tok_len;
    assign o_res.media_type     = head.media_type;
    assign o_res.last_result    = head.last_result;

endmodule
